// ===== rtl/crt_pkg.sv =====
// Shared types, codes and the region join function of the coalescing range table.
// Used by the top level.
`timescale 1ns / 1ps
`default_nettype none
package crt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FILTERED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd6;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCLUDE_RO = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_MASK  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_MATCH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_MASK = 2'd3;

   localparam logic [31:0] FLAG_MASK_RESET  = 32'd3;
   localparam logic [31:0] FLAG_MATCH_RESET = 32'd1;
   localparam logic [31:0] WRITE_MASK_RESET = 32'd512;
   localparam logic [63:0] UNMAPPED_ADDR    = '1;
   localparam int PROT_SHIFT = 8;

   typedef struct packed {
      logic [63:0] start;
      logic [63:0] len;
      logic [31:0] flags;
      logic [15:0] prot;
      logic [31:0] device;
      logic [63:0] inode;
      logic [15:0] object;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic      ok;
      entry_type entry;
   } join_type;

   // Grows dst by src when both share attributes and touch end to start.
   function automatic join_type try_join(entry_type dst, entry_type src);
      join_type res;
      res.ok = 1'b0;
      res.entry = dst;
      if (dst.flags == src.flags && dst.prot == src.prot && dst.device == src.device &&
          dst.inode == src.inode && dst.object == src.object) begin
         if (dst.start + dst.len == src.start) begin
            res.ok = 1'b1;
            res.entry.len = dst.len + src.len;
         end else if (src.start + src.len == dst.start) begin
            res.ok = 1'b1;
            res.entry.start = dst.start - src.len;
            res.entry.len = dst.len + src.len;
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/crt_req_if.sv =====
// Request and response channel interfaces of the coalescing range table.
// Depends on nothing but the field widths listed here.
`timescale 1ns / 1ps
`default_nettype none
interface crt_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [5:0]  entry_index;
   logic [63:0] start_addr;
   logic [63:0] region_len;
   logic [31:0] map_flags;
   logic [15:0] prot_bits;
   logic [31:0] device_id;
   logic [63:0] inode_id;
   logic [15:0] object_id;
   modport source (output valid, kind, entry_index, start_addr, region_len, map_flags,
                   prot_bits, device_id, inode_id, object_id, input ready);
   modport sink (input valid, kind, entry_index, start_addr, region_len, map_flags,
                 prot_bits, device_id, inode_id, object_id, output ready);
endinterface

interface crt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [6:0]  entry_count;
   logic [63:0] out_start;
   logic [63:0] out_len;
   logic [31:0] out_flags;
   logic [15:0] out_prot;
   logic [31:0] out_device;
   logic [63:0] out_inode;
   logic [15:0] out_object;
   modport source (output valid, status, entry_count, out_start, out_len, out_flags,
                   out_prot, out_device, out_inode, out_object, input ready);
   modport sink (input valid, status, entry_count, out_start, out_len, out_flags,
                 out_prot, out_device, out_inode, out_object, output ready);
endinterface
`default_nettype wire

// ===== rtl/crt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; used by the coalescing range table top level.
`timescale 1ns / 1ps
`default_nettype none
module crt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/coalescing_range_table_top.sv =====
// Top level of the coalescing range table: control sequencer around one entry RAM.
// Depends on crt_pkg, crt_req_if / crt_rsp_if and crt_ram.
//
//   channel   | direction | handshake       | contents
//   req_chan  | in        | valid / ready   | insert region or read index
//   rsp_chan  | out       | valid / ready   | status, entry count, read entry
//   csr_*     | in        | csr_we          | four filter registers
//
// The response register loads at the accepting edge for a filtered insert, a bad index or
// an insert into an empty table, in the next cycle for a read, and once the scan stops at
// entry p for other inserts (one entry per cycle through the RAM read port in S_SCAN).
// Opening a slot then moves each tail entry up in S_SHUP and writes the new entry in S_PUT;
// joining two entries adds S_JOIN2 and S_SHDN moves later ones down (single RAM write port).
// The slowest insert is one that opens a slot among the stored entries.
// Reset is synchronous and clears the entry count; entries beyond it are never used.
// A response waits in an output register; a new request is taken in the cycle it drains.
`timescale 1ns / 1ps
`default_nettype none
module coalescing_range_table_top #(
   parameter int TABLE_DEPTH = crt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   crt_req_if.sink                               req_chan,
   crt_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [crt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [crt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_JOIN2 = 3'd3;
   localparam logic [2:0] S_SHDN  = 3'd4;
   localparam logic [2:0] S_SHUP  = 3'd5;
   localparam logic [2:0] S_PUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, pos_ff, pos_in, tgt_ff, tgt_in;
   crt_pkg::entry_type item_ff, item_in, prev_ff, prev_in, cur_ff, cur_in;
   logic        incl_ro_ff;
   logic [31:0] flag_mask_ff, flag_match_ff, write_mask_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [crt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;
   crt_pkg::entry_type rsp_entry_ff, rsp_entry_in;

   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   crt_pkg::entry_type ram_wdata, ram_rdata;

   logic        req_ready;
   logic        fire;
   logic [crt_pkg::STATUS_W-1:0] fire_status;
   crt_pkg::entry_type fire_entry, in_entry;
   crt_pkg::join_type j_cr, j_pr, j_cp;
   logic [31:0] shifted;
   logic        filtered, full;
   logic [CW:0] pos_p1, tgt_p2;

   crt_ram #(.WIDTH(crt_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = req_ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.out_start   = rsp_entry_ff.start;
   assign rsp_chan.out_len     = rsp_entry_ff.len;
   assign rsp_chan.out_flags   = rsp_entry_ff.flags;
   assign rsp_chan.out_prot    = rsp_entry_ff.prot;
   assign rsp_chan.out_device  = rsp_entry_ff.device;
   assign rsp_chan.out_inode   = rsp_entry_ff.inode;
   assign rsp_chan.out_object  = rsp_entry_ff.object;

   always_comb begin
      in_entry.start  = req_chan.start_addr;
      in_entry.len    = req_chan.region_len;
      in_entry.flags  = req_chan.map_flags;
      in_entry.prot   = req_chan.prot_bits;
      in_entry.device = req_chan.device_id;
      in_entry.inode  = req_chan.inode_id;
      in_entry.object = req_chan.object_id;
   end

   assign shifted  = {8'd0, req_chan.prot_bits, 8'd0};
   assign filtered = (req_chan.start_addr == crt_pkg::UNMAPPED_ADDR) ||
                     ((req_chan.map_flags & flag_mask_ff) != flag_match_ff) ||
                     (!incl_ro_ff && ((shifted & write_mask_ff) != write_mask_ff));
   assign full   = (count_ff == CW'(TABLE_DEPTH));
   assign pos_p1 = {1'b0, pos_ff} + (CW+1)'(1);
   assign tgt_p2 = {1'b0, tgt_ff} + (CW+1)'(2);

   assign j_cr = crt_pkg::try_join(ram_rdata, item_ff);
   assign j_pr = crt_pkg::try_join(prev_ff, item_ff);
   assign j_cp = crt_pkg::try_join(cur_ff, prev_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      item_in  = item_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = item_ff;
      ram_raddr = '0;
      fire        = 1'b0;
      fire_status = crt_pkg::ST_INSERTED;
      fire_entry  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_ready) begin
               if (req_chan.kind) begin
                  if (32'(req_chan.entry_index) < 32'(count_ff)) begin
                     ram_raddr = AW'(req_chan.entry_index);
                     state_in = S_READ;
                  end else begin
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_BAD_INDEX;
                  end
               end else begin
                  item_in = in_entry;
                  if (filtered) begin
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_FILTERED;
                  end else if (count_ff == '0) begin
                     ram_we = 1'b1;
                     ram_wdata = in_entry;
                     count_in = CW'(1);
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_INSERTED;
                  end else begin
                     pos_in = '0;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_READ: begin
            fire = 1'b1;
            fire_status = crt_pkg::ST_READ_OK;
            fire_entry = ram_rdata;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // The RAM holds entry pos on its read data; the next read is issued now.
            ram_raddr = pos_p1[AW-1:0];
            if (item_ff.start == ram_rdata.start) begin
               fire = 1'b1;
               fire_status = crt_pkg::ST_DUPLICATE;
               state_in = S_IDLE;
            end else if (item_ff.start < ram_rdata.start) begin
               if (j_cr.ok) begin
                  if (pos_ff != '0) begin
                     cur_in = j_cr.entry;
                     state_in = S_JOIN2;
                  end else begin
                     ram_we = 1'b1;
                     ram_waddr = pos_ff[AW-1:0];
                     ram_wdata = j_cr.entry;
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_MERGED;
                     state_in = S_IDLE;
                  end
               end else if (pos_ff != '0 && j_pr.ok) begin
                  ram_we = 1'b1;
                  ram_waddr = AW'(pos_ff - CW'(1));
                  ram_wdata = j_pr.entry;
                  fire = 1'b1;
                  fire_status = crt_pkg::ST_MERGED;
                  state_in = S_IDLE;
               end else if (full) begin
                  fire = 1'b1;
                  fire_status = crt_pkg::ST_FULL;
                  state_in = S_IDLE;
               end else begin
                  // Open a slot at pos by moving the tail up one place, last entry first.
                  ram_raddr = AW'(count_ff - CW'(1));
                  tgt_in = count_ff;
                  state_in = S_SHUP;
               end
            end else begin
               prev_in = ram_rdata;
               if (pos_p1 == {1'b0, count_ff}) begin
                  state_in = S_IDLE;
                  if (j_cr.ok) begin
                     ram_we = 1'b1;
                     ram_waddr = pos_ff[AW-1:0];
                     ram_wdata = j_cr.entry;
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_MERGED;
                  end else if (full) begin
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_FULL;
                  end else begin
                     ram_we = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     fire = 1'b1;
                     fire_status = crt_pkg::ST_INSERTED;
                  end
               end else begin
                  pos_in = pos_p1[CW-1:0];
               end
            end
         end
         S_JOIN2: begin
            if (j_cp.ok) begin
               // The grown entry also reaches back to its predecessor: join and close up.
               ram_we = 1'b1;
               ram_waddr = AW'(pos_ff - CW'(1));
               ram_wdata = j_cp.entry;
               if (pos_p1 < {1'b0, count_ff}) begin
                  ram_raddr = pos_p1[AW-1:0];
                  tgt_in = pos_ff;
                  state_in = S_SHDN;
               end else begin
                  count_in = count_ff - CW'(1);
                  fire = 1'b1;
                  fire_status = crt_pkg::ST_MERGED;
                  state_in = S_IDLE;
               end
            end else begin
               ram_we = 1'b1;
               ram_waddr = pos_ff[AW-1:0];
               ram_wdata = cur_ff;
               fire = 1'b1;
               fire_status = crt_pkg::ST_MERGED;
               state_in = S_IDLE;
            end
         end
         S_SHDN: begin
            ram_we = 1'b1;
            ram_waddr = tgt_ff[AW-1:0];
            ram_wdata = ram_rdata;
            if (tgt_p2 < {1'b0, count_ff}) begin
               ram_raddr = tgt_p2[AW-1:0];
               tgt_in = tgt_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               fire = 1'b1;
               fire_status = crt_pkg::ST_MERGED;
               state_in = S_IDLE;
            end
         end
         S_SHUP: begin
            ram_we = 1'b1;
            ram_waddr = tgt_ff[AW-1:0];
            ram_wdata = ram_rdata;
            if (tgt_ff - CW'(1) > pos_ff) begin
               ram_raddr = AW'(tgt_ff - CW'(2));
               tgt_in = tgt_ff - CW'(1);
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            ram_we = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            count_in = count_ff + CW'(1);
            fire = 1'b1;
            fire_status = crt_pkg::ST_INSERTED;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fire_status;
         rsp_count_in  = 7'(count_in);
         rsp_entry_in  = fire_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         incl_ro_ff    <= 1'b0;
         flag_mask_ff  <= crt_pkg::FLAG_MASK_RESET;
         flag_match_ff <= crt_pkg::FLAG_MATCH_RESET;
         write_mask_ff <= crt_pkg::WRITE_MASK_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               crt_pkg::CSR_INCLUDE_RO: incl_ro_ff    <= csr_wdata[0];
               crt_pkg::CSR_FLAG_MASK:  flag_mask_ff  <= csr_wdata;
               crt_pkg::CSR_FLAG_MATCH: flag_match_ff <= csr_wdata;
               crt_pkg::CSR_WRITE_MASK: write_mask_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      tgt_ff        <= tgt_in;
      item_ff       <= item_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + CW'(1) ||
                         count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a request is still in progress");

endmodule
`default_nettype wire
